// File: src/lbc_pkg.sv
package lbc_pkg;

   localparam int MAX_ENTRIES_DEF     = 256;
   localparam int WORDS_PER_BLOCK_DEF = 32;
   localparam int N_W                 = 13;
   localparam int CSR_DATA_W          = 9;
   localparam int COUNT_W             = 32;
   localparam int META_W              = 4 + 8 + COUNT_W;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_UPDATE = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_MISS = 2'd1,
      STATUS_OFF  = 2'd2
   } status_type;

   typedef enum logic {
      CSR_ENABLE  = 1'b0,
      CSR_ENTRIES = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_CONT_RD,
      ST_CONT_CK,
      ST_WRITE,
      ST_STREAM
   } state_type;

   typedef struct packed {
      logic           enable;
      logic           clear;
      logic [N_W-1:0] n;
   } cfg_type;

endpackage

// File: src/lfu_block_cache_core.sv
// Fully associative disk-block cache with least-frequently-used replacement.
// A lookup, or an insert or update of word 0, takes one pass over the entries
// in use (n = entries_in_use, clamped to 2..MAX_ENTRIES): one tag/count read
// per cycle from the metadata RAM; a lookup hit then streams WORDS_PER_BLOCK
// words on consecutive cycles. A continuation word reads and checks its slot,
// then writes; rejected or disabled requests answer the cycle after start.
// busy covers the last streamed word but is low while a single result shows.
// Results appear for one cycle each under rsp_valid; the receiver cannot stall.
module lfu_block_cache_core import lbc_pkg::*; #(
   parameter int MAX_ENTRIES     = MAX_ENTRIES_DEF,
   parameter int WORDS_PER_BLOCK = WORDS_PER_BLOCK_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_op,
   input  logic [3:0]            req_disk_number,
   input  logic [7:0]            req_block_number,
   input  logic [4:0]            req_word_index,
   input  logic [63:0]           req_data_word,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_status,
   output logic [63:0]           rsp_out_word,
   output logic [4:0]            rsp_out_index,
   output logic                  rsp_last,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int NW = (N_W > CSR_DATA_W) ? N_W : CSR_DATA_W;

   logic                  enable_ff;
   logic [CSR_DATA_W-1:0] entries_ff;
   logic                  clear_ff;
   logic [NW-1:0]         n_ext;
   cfg_type               cfg;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         entries_ff <= CSR_DATA_W'(256);
         clear_ff   <= 1'b0;
      end else begin
         clear_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ENABLE: begin
                  enable_ff <= csr_data[0];
                  clear_ff  <= !csr_data[0];
               end
               CSR_ENTRIES: entries_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      n_ext = NW'(entries_ff);
      if (n_ext < NW'(2)) begin
         n_ext = NW'(2);
      end else if (n_ext > NW'(MAX_ENTRIES)) begin
         n_ext = NW'(MAX_ENTRIES);
      end
   end

   assign cfg.enable = enable_ff;
   assign cfg.clear  = clear_ff;
   assign cfg.n      = n_ext[N_W-1:0];

   lbc_ctrl #(.MAX_ENTRIES(MAX_ENTRIES), .WORDS_PER_BLOCK(WORDS_PER_BLOCK)) u_ctrl (
      .clock(clock), .reset(reset), .cfg(cfg), .start(start), .busy(busy),
      .req_op(req_op), .req_disk_number(req_disk_number),
      .req_block_number(req_block_number), .req_word_index(req_word_index),
      .req_data_word(req_data_word), .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_out_word(rsp_out_word), .rsp_out_index(rsp_out_index), .rsp_last(rsp_last)
   );

endmodule

// File: src/lbc_ram.sv
module lbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// File: src/lbc_ctrl.sv
module lbc_ctrl import lbc_pkg::*; #(
   parameter int MAX_ENTRIES     = MAX_ENTRIES_DEF,
   parameter int WORDS_PER_BLOCK = WORDS_PER_BLOCK_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [3:0]  req_disk_number,
   input  logic [7:0]  req_block_number,
   input  logic [4:0]  req_word_index,
   input  logic [63:0] req_data_word,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [63:0] rsp_out_word,
   output logic [4:0]  rsp_out_index,
   output logic        rsp_last
);

   localparam int IW    = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int KW    = $clog2(WORDS_PER_BLOCK + 1);
   localparam int BDEP  = MAX_ENTRIES * WORDS_PER_BLOCK;
   localparam int BAW   = $clog2(BDEP);

   state_type state_ff, state_in;

   logic [1:0]  op_ff;
   logic [3:0]  disk_ff;
   logic [7:0]  blk_ff;
   logic [4:0]  word_ff;
   logic [63:0] data_ff;

   logic [MAX_ENTRIES-1:0] valid_ff;
   logic [IW-1:0]          pend_slot_ff;
   logic                   pend_ok_ff;

   logic [CNT_W-1:0]   cnt_ff;
   logic               chk_ff;
   logic [IW-1:0]      chk_idx_ff;
   logic               hit_found_ff, free_found_ff;
   logic [IW-1:0]      hit_idx_ff, free_idx_ff, min_idx_ff;
   logic [COUNT_W-1:0] hit_cnt_ff, min_cnt_ff;

   logic [BAW-1:0] base_ff;
   logic [KW-1:0]  k_ff;

   logic       single_vld_ff;
   status_type single_status_ff;
   logic       str_pend_ff;
   logic [4:0] str_idx_ff;
   logic       str_last_ff;

   logic [CNT_W-1:0] n;
   logic             accept;
   logic             scan_done;
   logic             word_oob;

   logic               meta_we;
   logic [IW-1:0]      meta_waddr, meta_raddr;
   logic [META_W-1:0]  meta_wdata, meta_rdata;
   logic [3:0]         m_disk;
   logic [7:0]         m_blk;
   logic [COUNT_W-1:0] m_cnt;
   logic               blk_we;
   logic [BAW-1:0]     blk_waddr, blk_raddr;
   logic [63:0]        blk_rdata;

   logic [IW-1:0]      ins_idx;
   logic [COUNT_W-1:0] hit_bump;
   logic               cont_ok;

   assign n         = CNT_W'(cfg.n);
   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE) || str_pend_ff;
   assign scan_done = (cnt_ff == n) && !chk_ff;
   assign word_oob  = 7'(req_word_index) >= 7'(WORDS_PER_BLOCK);
   assign m_disk    = meta_rdata[META_W-1 -: 4];
   assign m_blk     = meta_rdata[COUNT_W +: 8];
   assign m_cnt     = meta_rdata[COUNT_W-1:0];
   assign ins_idx   = free_found_ff ? free_idx_ff : min_idx_ff;
   assign hit_bump  = (hit_cnt_ff == '1) ? hit_cnt_ff : hit_cnt_ff + COUNT_W'(1);
   assign cont_ok   = pend_ok_ff && (CNT_W'(pend_slot_ff) < n) && valid_ff[pend_slot_ff]
                      && (m_disk == disk_ff) && (m_blk == blk_ff);

   lbc_ram #(.WIDTH(META_W), .DEPTH(MAX_ENTRIES)) u_meta (
      .clock(clock), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
      .raddr(meta_raddr), .rdata(meta_rdata)
   );

   lbc_ram #(.WIDTH(64), .DEPTH(BDEP)) u_block (
      .clock(clock), .we(blk_we), .waddr(blk_waddr), .wdata(data_ff),
      .raddr(blk_raddr), .rdata(blk_rdata)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && cfg.enable && (req_op != OP_NONE)) begin
               if (req_op == OP_LOOKUP) begin
                  state_in = ST_SCAN;
               end else if (!word_oob && (req_word_index != 5'd0)) begin
                  state_in = ST_CONT_RD;
               end else if (!word_oob) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (op_ff == OP_LOOKUP) begin
               state_in = hit_found_ff ? ST_STREAM : ST_IDLE;
            end else if (op_ff == OP_INSERT) begin
               state_in = hit_found_ff ? ST_IDLE : ST_WRITE;
            end else begin
               state_in = hit_found_ff ? ST_WRITE : ST_IDLE;
            end
         end
         ST_CONT_RD: state_in = ST_CONT_CK;
         ST_CONT_CK: state_in = cont_ok ? ST_WRITE : ST_IDLE;
         ST_WRITE:   state_in = ST_IDLE;
         ST_STREAM: begin
            if (k_ff == KW'(WORDS_PER_BLOCK - 1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      meta_we    = 1'b0;
      meta_waddr = hit_idx_ff;
      meta_wdata = {disk_ff, blk_ff, hit_bump};
      meta_raddr = (state_ff == ST_CONT_RD) ? pend_slot_ff : cnt_ff[IW-1:0];
      blk_we     = 1'b0;
      blk_waddr  = base_ff + BAW'(word_ff);
      blk_raddr  = base_ff + BAW'(k_ff);
      case (state_ff)
         ST_DECIDE: begin
            if (op_ff == OP_INSERT) begin
               meta_we    = !hit_found_ff;
               meta_waddr = ins_idx;
               meta_wdata = {disk_ff, blk_ff, COUNT_W'(1)};
            end else if (op_ff == OP_LOOKUP || op_ff == OP_UPDATE) begin
               meta_we = hit_found_ff;
            end
         end
         ST_WRITE: blk_we = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         pend_slot_ff  <= '0;
         pend_ok_ff    <= 1'b0;
         chk_ff        <= 1'b0;
         single_vld_ff <= 1'b0;
         str_pend_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         single_vld_ff <= 1'b0;
         str_pend_ff   <= 1'b0;
         chk_ff        <= 1'b0;
         if (cfg.clear) begin
            valid_ff   <= '0;
            pend_slot_ff <= '0;
            pend_ok_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  op_ff         <= req_op;
                  disk_ff       <= req_disk_number;
                  blk_ff        <= req_block_number;
                  word_ff       <= req_word_index;
                  data_ff       <= req_data_word;
                  cnt_ff        <= '0;
                  hit_found_ff  <= 1'b0;
                  free_found_ff <= 1'b0;
                  k_ff          <= '0;
                  if (!cfg.enable) begin
                     single_vld_ff    <= 1'b1;
                     single_status_ff <= STATUS_OFF;
                  end else if (req_op == OP_NONE ||
                               (req_op != OP_LOOKUP && word_oob)) begin
                     single_vld_ff    <= 1'b1;
                     single_status_ff <= STATUS_MISS;
                  end
               end
            end
            ST_SCAN: begin
               if (cnt_ff != n) begin
                  chk_ff     <= 1'b1;
                  chk_idx_ff <= cnt_ff[IW-1:0];
                  cnt_ff     <= cnt_ff + CNT_W'(1);
               end
               if (chk_ff) begin
                  if (valid_ff[chk_idx_ff] && m_disk == disk_ff && m_blk == blk_ff
                      && !hit_found_ff) begin
                     hit_found_ff <= 1'b1;
                     hit_idx_ff   <= chk_idx_ff;
                     hit_cnt_ff   <= m_cnt;
                  end
                  if (!valid_ff[chk_idx_ff] && !free_found_ff) begin
                     free_found_ff <= 1'b1;
                     free_idx_ff   <= chk_idx_ff;
                  end
                  if (chk_idx_ff == '0 || m_cnt < min_cnt_ff) begin
                     min_idx_ff <= chk_idx_ff;
                     min_cnt_ff <= m_cnt;
                  end
               end
            end
            ST_DECIDE: begin
               if (op_ff == OP_INSERT && !hit_found_ff) begin
                  valid_ff[ins_idx] <= 1'b1;
                  pend_slot_ff      <= ins_idx;
                  pend_ok_ff        <= 1'b1;
                  base_ff           <= BAW'(ins_idx) * BAW'(WORDS_PER_BLOCK);
               end else if (hit_found_ff) begin
                  base_ff <= BAW'(hit_idx_ff) * BAW'(WORDS_PER_BLOCK);
                  if (op_ff == OP_UPDATE) begin
                     pend_slot_ff <= hit_idx_ff;
                     pend_ok_ff   <= 1'b1;
                  end
               end
               if ((op_ff == OP_INSERT) == hit_found_ff) begin
                  if (op_ff != OP_LOOKUP) begin
                     pend_ok_ff <= 1'b0;
                  end
                  single_vld_ff    <= 1'b1;
                  single_status_ff <= STATUS_MISS;
               end
            end
            ST_CONT_CK: begin
               base_ff <= BAW'(pend_slot_ff) * BAW'(WORDS_PER_BLOCK);
               if (!cont_ok) begin
                  single_vld_ff    <= 1'b1;
                  single_status_ff <= STATUS_MISS;
               end
            end
            ST_WRITE: begin
               single_vld_ff    <= 1'b1;
               single_status_ff <= STATUS_OK;
            end
            ST_STREAM: begin
               str_pend_ff <= 1'b1;
               str_idx_ff  <= 5'(k_ff);
               str_last_ff <= (k_ff == KW'(WORDS_PER_BLOCK - 1));
               k_ff        <= k_ff + KW'(1);
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid     = single_vld_ff || str_pend_ff;
   assign rsp_status    = str_pend_ff ? STATUS_OK : single_status_ff;
   assign rsp_out_word  = str_pend_ff ? blk_rdata : 64'd0;
   assign rsp_out_index = str_pend_ff ? str_idx_ff : 5'd0;
   assign rsp_last      = str_pend_ff ? str_last_ff : 1'b1;

   a_one_source: assert property (@(posedge clock) disable iff (reset)
      !(single_vld_ff && str_pend_ff)) else $error("two result sources at once");

   a_stream_runs: assert property (@(posedge clock) disable iff (reset)
      (str_pend_ff && !str_last_ff) |=> str_pend_ff) else $error("block stream broken");

   a_write_open: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> pend_ok_ff) else $error("write without open transfer");

   a_busy_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |=> busy) else $error("idle during scan");

endmodule
